[design/arht_pkg.sv]
// Shared types and constants for the address range hook table.
`default_nettype none

package arht_pkg;

    localparam int ENTRIES_PER_KIND = 16;
    localparam int TOTAL_SLOTS      = 2 * ENTRIES_PER_KIND;
    localparam int SLOT_W           = (ENTRIES_PER_KIND > 1) ? $clog2(ENTRIES_PER_KIND) : 1;
    localparam int IDX_W            = $clog2(TOTAL_SLOTS);

    localparam int ADDR_W     = 16;
    localparam int HANDLER_W  = 8;
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } ins_status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_RES  = 3'b100
    } state_t;

    typedef struct packed {
        logic load_item;
        logic capture;
        logic commit;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

[design/arht_ctrl.sv]
// Controller state machine for the address range hook table.
`default_nettype none

module arht_ctrl
    import arht_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   s_fire;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd.load_item = s_fire;
        cmd.capture   = (state_reg == S_CMP);
        // The result may only be committed once the output register is free.
        cmd.commit    = (state_reg == S_RES) && (!out_valid_reg || m_tready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_RES;
            end
            S_RES: begin
                if (cmd.commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == S_CMP) ##1 (state_reg == S_RES))
        else $error("accepted item did not pass through compare and resolve");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !cmd.commit)
        else $error("result committed over a waiting item");

endmodule

`default_nettype wire

[design/arht_datapath.sv]
// Range tables, parallel comparators and result register.
`default_nettype none

module arht_datapath
    import arht_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ctrl_cmd_t            cmd,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    // Captured item.
    logic                 opcode_reg;
    logic                 kind_reg;
    logic [ADDR_W-1:0]    start_reg;
    logic [ADDR_W-1:0]    end_reg;
    logic [HANDLER_W-1:0] handler_in_reg;
    logic [ADDR_W-1:0]    addr_reg;

    // Slot register file; slots of the write kind follow those of the read kind.
    logic                 valid_reg [TOTAL_SLOTS];
    logic [ADDR_W-1:0]    entry_start_reg [TOTAL_SLOTS];
    logic [ADDR_W-1:0]    entry_end_reg [TOTAL_SLOTS];
    logic [HANDLER_W-1:0] entry_handler_reg [TOTAL_SLOTS];

    logic [TOTAL_SLOTS-1:0] match_reg, match_next;
    logic [TOTAL_SLOTS-1:0] ovl_reg, ovl_next;
    logic [TOTAL_SLOTS-1:0] valid_vec;

    logic [M_TDATA_W-1:0] out_data_reg;

    ins_status_t          status_c;
    logic                 hit_c;
    logic [HANDLER_W-1:0] handler_c;
    logic                 any_free;
    logic [SLOT_W-1:0]    free_idx;
    logic [IDX_W-1:0]     wr_idx;
    logic                 do_write;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            opcode_reg     <= s_tuser[0];
            kind_reg       <= s_tuser[1];
            start_reg      <= s_tdata[15:0];
            end_reg        <= s_tdata[31:16];
            handler_in_reg <= s_tdata[39:32];
            addr_reg       <= s_tdata[55:40];
        end
    end

    // One comparator pair per slot, masked to the selected kind.
    always_comb begin
        for (int j = 0; j < TOTAL_SLOTS; j++) begin
            logic in_kind;
            in_kind = ((j >= ENTRIES_PER_KIND) == kind_reg) && valid_reg[j];
            match_next[j] = in_kind && (entry_start_reg[j] <= addr_reg)
                            && (addr_reg < entry_end_reg[j]);
            ovl_next[j]   = in_kind && (start_reg < entry_end_reg[j])
                            && (entry_start_reg[j] < end_reg);
            valid_vec[j]  = valid_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            match_reg <= match_next;
            ovl_reg   <= ovl_next;
        end
    end

    // Lowest free slot of the selected kind.
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES_PER_KIND - 1; i >= 0; i--) begin
            if (!(kind_reg ? valid_reg[ENTRIES_PER_KIND + i] : valid_reg[i])) begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
        wr_idx = kind_reg ? (IDX_W'(ENTRIES_PER_KIND) + IDX_W'(free_idx))
                          : IDX_W'(free_idx);
    end

    // Stored ranges are disjoint, so at most one match bit is set.
    always_comb begin
        handler_c = '0;
        for (int j = 0; j < TOTAL_SLOTS; j++) begin
            handler_c = handler_c | ({HANDLER_W{match_reg[j]}} & entry_handler_reg[j]);
        end
        hit_c    = |match_reg;
        status_c = ST_OK;
        do_write = 1'b0;
        if (opcode_reg == OP_LOOKUP) begin
            status_c = ST_OK;
        end else begin
            hit_c     = 1'b0;
            handler_c = '0;
            if (!(start_reg < end_reg)) begin
                status_c = ST_EMPTY;
            end else if (|ovl_reg) begin
                status_c = ST_OVERLAP;
            end else if (!any_free) begin
                status_c = ST_FULL;
            end else begin
                do_write = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < TOTAL_SLOTS; j++) begin
                valid_reg[j] <= 1'b0;
            end
        end else if (cmd.commit && do_write) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && do_write) begin
            entry_start_reg[wr_idx]   <= start_reg;
            entry_end_reg[wr_idx]     <= end_reg;
            entry_handler_reg[wr_idx] <= handler_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= {5'b0, handler_c, hit_c, status_c};
        end
    end

    assign m_tdata = out_data_reg;

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> $onehot0(match_reg))
        else $error("address matched more than one stored range");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && do_write) |=>
            ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
        else $error("accepted insert did not occupy exactly one slot");

    a_no_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit && do_write) |=> ($countones(valid_vec) == $past($countones(valid_vec))))
        else $error("slot occupancy changed without an accepted insert");

endmodule

`default_nettype wire

[design/address_range_hook_table.sv]
// Top level of the address range hook table.
//
// Two tables of disjoint half-open address ranges, one for read hooks and
// one for write hooks, each with a handler number per range. An input item
// on the s_ channel either inserts a range or looks up an address; every
// item gives exactly one result item on the m_ channel.
// An item is accepted only while the block is idle. The cycle after the
// accept, all slots are compared against the item in parallel and the
// match and overlap vectors are registered; in the resolve step that
// follows they are reduced and the lowest free slot is chosen, and once
// the output register is free an accepted range is written and the result
// item is loaded into the output register. m_tvalid is registered from
// that load, and the next item can be taken once the result is loaded.
// When the receiver stalls, the result waits in the output register while
// the next item is already accepted and compared; that item then holds in
// its resolve step until the output register is free.
// Reset empties both tables and drops any pending result.
`default_nettype none

module address_range_hook_table
    import arht_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // range_start[15:0], range_end[31:16], handler_id[39:32], query_addr[55:40]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // opcode[0], access_kind[1]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // insert_status[1:0], hit[2], found_handler[10:3], zero[15:11]
    output logic      [M_TDATA_W-1:0] m_tdata
);

    ctrl_cmd_t cmd;

    arht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    arht_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire
